>>> sv/mpjs_pkg.sv
// mpjs_pkg: shared types and constants for the multi-policy job scheduler
// used by mpjs_ctrl, mpjs_dp and the top level
package mpjs_pkg;

  localparam logic [1:0] POL_FIFO = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_SJF  = 2'd2;
  localparam logic [1:0] POL_PSJF = 2'd3;

  localparam logic CFG_POLICY  = 1'b0;
  localparam logic CFG_QUANTUM = 1'b1;

  localparam logic [15:0] QUANTUM_RESET = 16'd500;
  localparam int OUT_IDX_W = 6;

  // controller to datapath commands
  typedef struct packed {
    logic capture;     // latch input beat
    logic arrive;      // do arrival update
    logic scan_clr;    // start table scan
    logic scan_step;   // process one table entry
    logic rr_pop;      // round robin: pop one ring entry
    logic rr_decide;   // first decision step of a tick
    logic commit;      // decrement running job, build result
    logic ring_rd;     // issue ring read at head
    logic norm_start;  // start slice counter reduction
    logic norm_step;   // one bit of slice counter reduction
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_tick;
    logic scan_last;   // last entry of scan
    logic need_scan;   // tick needs a table scan
    logic need_ring;   // tick needs ring pops
    logic ring_empty;
    logic pop_hit;     // popped entry is live
    logic slice_big;   // round robin slice counter not below quantum
    logic norm_last;   // last bit of slice counter reduction
  } sts_t;

endpackage

>>> sv/mpjs_ctrl.sv
// mpjs_ctrl: sequencing state machine for the job scheduler
// depends on mpjs_pkg; drives mpjs_dp through cmd_t, reads sts_t
module mpjs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  mpjs_pkg::sts_t sts,
  output mpjs_pkg::cmd_t cmd
);
  import mpjs_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b00000001,
    S_DEC    = 8'b00000010,
    S_SCAN   = 8'b00000100,
    S_RRREQ  = 8'b00001000,
    S_RRPOP  = 8'b00010000,
    S_COMMIT = 8'b00100000,
    S_OUT    = 8'b01000000,
    S_NORM   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.is_tick) begin
          cmd.arrive = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.slice_big) begin
          cmd.norm_start = 1'b1;
          state_nxt = S_NORM;
        end else begin
          cmd.rr_decide = 1'b1;
          cmd.ring_rd = 1'b1;
          if (sts.need_scan) begin
            cmd.scan_clr = 1'b1;
            state_nxt = S_SCAN;
          end else if (sts.need_ring) begin
            state_nxt = S_RRREQ;
          end else begin
            state_nxt = S_COMMIT;
          end
        end
      end
      S_NORM: begin
        cmd.norm_step = 1'b1;
        if (sts.norm_last) state_nxt = S_DEC;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_RRREQ: begin
        // ring read data lands this cycle
        state_nxt = S_RRPOP;
      end
      S_RRPOP: begin
        if (sts.ring_empty) begin
          state_nxt = S_COMMIT;
        end else begin
          cmd.rr_pop = 1'b1;
          cmd.ring_rd = 1'b1;
          state_nxt = sts.pop_hit ? S_COMMIT : S_RRREQ;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> sv/mpjs_dp.sv
// mpjs_dp: job table, ready ring, policy state and result registers
// depends on mpjs_pkg; commanded by mpjs_ctrl
module mpjs_dp #(
  parameter int MAX_JOBS  = 64,
  parameter int TIME_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_mode,
  input  logic [23:0]                    in_exec_time,
  input  logic                           in_last_job,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [15:0]                    cfg_wdata,
  input  mpjs_pkg::cmd_t                 cmd,
  output mpjs_pkg::sts_t                 sts,
  output logic [mpjs_pkg::OUT_IDX_W-1:0] out_job_index,
  output logic                           out_idle,
  output logic                           out_job_done,
  output logic                           out_rejected,
  output logic                           out_all_done
);
  import mpjs_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_JOBS);
  localparam logic [IW-1:0] IDX_LAST = IW'(MAX_JOBS - 1);

  logic [TIME_BITS-1:0] rt_mem [MAX_JOBS];
  logic [IW-1:0]        ring_mem [MAX_JOBS];

  logic [1:0]  policy_r;
  logic [15:0] quantum_r;

  logic                 mode_r, last_r;
  logic [TIME_BITS-1:0] exec_r;

  logic [CW-1:0] arrived_r, finished_r, ring_cnt_r;
  logic [IW-1:0] run_slot_r, head_r, tail_r;
  logic          run_valid_r, pend_r, last_seen_r;
  logic [15:0]   slice_r;

  // running job remaining time, kept beside the table
  logic [TIME_BITS-1:0] run_rt_r;

  // scan state
  logic [IW-1:0]        scan_i_r;
  logic                 found_r;
  logic [IW-1:0]        best_i_r;
  logic [TIME_BITS-1:0] best_t_r;

  // table read port
  logic [IW-1:0]        rd_addr;
  logic [TIME_BITS-1:0] rd_data_r;
  logic [IW-1:0]        ring_q_r;
  logic [IW-1:0]        ring_mem_q;

  // selection result
  logic                 sel_ok_r;
  logic [IW-1:0]        sel_slot_r;
  logic [TIME_BITS-1:0] sel_rt_r;

  logic [15:0] q_eff;
  logic        run_live;
  logic        keep_rr;
  logic        slice_zero;

  assign q_eff      = (quantum_r == 16'd0) ? 16'd1 : quantum_r;
  assign run_live   = run_valid_r && (run_rt_r != '0);
  assign slice_zero = (slice_r == 16'd0);
  assign keep_rr    = run_live && !slice_zero;

  // slice counter remainder by the quantum, one bit a cycle
  logic [15:0] norm_div_r, norm_rem_r;
  logic [3:0]  norm_cnt_r;
  logic [16:0] norm_sh;
  logic [15:0] norm_rem_nxt;
  assign norm_sh      = {norm_rem_r, norm_div_r[15]};
  assign norm_rem_nxt = (norm_sh >= {1'b0, q_eff}) ? 16'(norm_sh - {1'b0, q_eff})
                                                   : norm_sh[15:0];

  always_ff @(posedge clk) begin
    if (cmd.norm_start) begin
      norm_div_r <= slice_r;
      norm_rem_r <= '0;
      norm_cnt_r <= '0;
    end else if (cmd.norm_step) begin
      norm_div_r <= {norm_div_r[14:0], 1'b0};
      norm_rem_r <= norm_rem_nxt;
      norm_cnt_r <= norm_cnt_r + 4'd1;
    end
  end

  always_comb begin
    sts = '0;
    sts.is_tick    = mode_r;
    sts.scan_last  = (CW'(scan_i_r) + CW'(1) >= arrived_r);
    sts.need_scan  = 1'b0;
    sts.need_ring  = 1'b0;
    unique case (policy_r)
      POL_FIFO: sts.need_scan = (arrived_r != '0);
      POL_RR:   sts.need_ring = !keep_rr;
      POL_SJF:  sts.need_scan = !run_live && (arrived_r != '0);
      POL_PSJF: sts.need_scan = (pend_r || !run_live) && (arrived_r != '0);
      default:  sts.need_scan = 1'b0;
    endcase
    sts.ring_empty = (ring_cnt_r == '0);
    sts.pop_hit    = (CW'(ring_q_r) < arrived_r) && (rd_data_r != '0);
    sts.slice_big  = (policy_r == POL_RR) && (slice_r >= q_eff);
    sts.norm_last  = (norm_cnt_r == 4'd15);
  end

  // registered table read: scan index or popped ring slot
  always_comb begin
    if (cmd.scan_step || cmd.scan_clr) rd_addr = cmd.scan_clr ? '0 : scan_i_r + IW'(1);
    else                               rd_addr = ring_mem_q;
  end

  logic [IW-1:0] ring_rd_addr;
  // head after this cycle's pop
  assign ring_rd_addr = cmd.rr_pop ? ((head_r == IDX_LAST) ? '0 : head_r + IW'(1)) : head_r;

  // ring write: push of preempted job or arriving job
  logic          push_en;
  logic [IW-1:0] push_val;
  always_comb begin
    push_en  = 1'b0;
    push_val = '0;
    if (cmd.arrive && (arrived_r < CNT_MAX) && (exec_r != '0) && (policy_r == POL_RR)) begin
      push_en  = 1'b1;
      push_val = arrived_r[IW-1:0];
    end else if (cmd.rr_decide && policy_r == POL_RR && !keep_rr && run_live) begin
      push_en  = 1'b1;
      push_val = run_slot_r;
    end
    if (ring_cnt_r >= CNT_MAX) push_en = 1'b0;
  end

  // a read issued with a push into an empty ring returns the pushed value
  always_ff @(posedge clk) begin
    if (cmd.ring_rd) begin
      if (push_en && (tail_r == ring_rd_addr)) ring_mem_q <= push_val;
      else                                     ring_mem_q <= ring_mem[ring_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) ring_mem[tail_r] <= push_val;
  end

  // table memory: one write port, one registered read
  logic                 tw_en;
  logic [IW-1:0]        tw_addr;
  logic [TIME_BITS-1:0] tw_data;
  logic [TIME_BITS-1:0] dec_rt;
  assign dec_rt = sel_rt_r - TIME_BITS'(1);

  always_comb begin
    tw_en = 1'b0; tw_addr = '0; tw_data = '0;
    if (cmd.arrive && (arrived_r < CNT_MAX)) begin
      tw_en = 1'b1; tw_addr = arrived_r[IW-1:0]; tw_data = exec_r;
    end else if (cmd.commit && sel_ok_r) begin
      tw_en = 1'b1; tw_addr = sel_slot_r; tw_data = dec_rt;
    end
  end

  always_ff @(posedge clk) begin
    if (tw_en) rt_mem[tw_addr] <= tw_data;
    rd_data_r <= rt_mem[rd_addr];
  end

  // ring read address tracks where the popped slot reads the table
  always_ff @(posedge clk) begin
    ring_q_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POL_FIFO;
      quantum_r   <= QUANTUM_RESET;
      arrived_r   <= '0;
      finished_r  <= '0;
      ring_cnt_r  <= '0;
      run_slot_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      run_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      last_seen_r <= 1'b0;
      slice_r     <= '0;
      sel_ok_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_POLICY) policy_r  <= cfg_wdata[1:0];
        else                         quantum_r <= cfg_wdata;
      end
      if (push_en) begin
        tail_r <= (tail_r == IDX_LAST) ? '0 : tail_r + IW'(1);
      end
      if (push_en && !cmd.rr_pop) ring_cnt_r <= ring_cnt_r + CW'(1);
      else if (!push_en && cmd.rr_pop) ring_cnt_r <= ring_cnt_r - CW'(1);
      if (cmd.rr_pop) head_r <= (head_r == IDX_LAST) ? '0 : head_r + IW'(1);

      if (cmd.norm_step && sts.norm_last) slice_r <= norm_rem_nxt;

      if (cmd.arrive) begin
        if (arrived_r < CNT_MAX) begin
          arrived_r <= arrived_r + CW'(1);
          if (exec_r == '0) finished_r <= finished_r + CW'(1);
          pend_r <= 1'b1;
        end
        if (last_r) last_seen_r <= 1'b1;
      end

      if (cmd.rr_decide) begin
        // default: keep running job
        sel_ok_r   <= run_live;
        sel_slot_r <= run_slot_r;
        sel_rt_r   <= run_rt_r;
        if (policy_r == POL_RR) begin
          if (keep_rr) slice_r <= (slice_r + 16'd1 >= q_eff) ? 16'd0 : slice_r + 16'd1;
          else         slice_r <= (q_eff == 16'd1) ? 16'd0 : 16'd1;
          if (!keep_rr) sel_ok_r <= 1'b0;
        end else if (policy_r == POL_FIFO) begin
          sel_ok_r <= 1'b0;
        end else if (policy_r == POL_PSJF) begin
          pend_r <= 1'b0;
          if (pend_r) sel_ok_r <= 1'b0;
        end else if (!run_live) begin
          sel_ok_r <= 1'b0;
        end
      end

      if (cmd.scan_clr) begin
        scan_i_r <= '0;
        found_r  <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_i_r <= scan_i_r + IW'(1);
        if (rd_data_r != '0 && !found_r) begin
          found_r <= 1'b1; best_i_r <= scan_i_r; best_t_r <= rd_data_r;
        end else if (rd_data_r != '0 && policy_r != POL_FIFO && rd_data_r < best_t_r) begin
          best_i_r <= scan_i_r; best_t_r <= rd_data_r;
        end
        if (sts.scan_last) begin
          if (rd_data_r != '0 && !found_r) begin
            sel_ok_r <= 1'b1; sel_slot_r <= scan_i_r; sel_rt_r <= rd_data_r;
          end else if (rd_data_r != '0 && policy_r != POL_FIFO && rd_data_r < best_t_r) begin
            sel_ok_r <= 1'b1; sel_slot_r <= scan_i_r; sel_rt_r <= rd_data_r;
          end else begin
            sel_ok_r <= found_r; sel_slot_r <= best_i_r; sel_rt_r <= best_t_r;
          end
        end
      end

      if (cmd.rr_pop && sts.pop_hit) begin
        sel_ok_r <= 1'b1; sel_slot_r <= ring_q_r; sel_rt_r <= rd_data_r;
      end

      if (cmd.commit) begin
        run_valid_r <= sel_ok_r && (dec_rt != '0);
        if (sel_ok_r) begin
          run_slot_r <= sel_slot_r;
          run_rt_r   <= dec_rt;
          if (dec_rt == '0) finished_r <= finished_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      exec_r <= TIME_BITS'(in_exec_time);
      last_r <= in_last_job;
    end
  end

  // result registers
  logic [OUT_IDX_W-1:0] idx_r;
  logic idle_r, done_r, rej_r;
  always_ff @(posedge clk) begin
    if (cmd.arrive) begin
      idx_r  <= (arrived_r < CNT_MAX) ? OUT_IDX_W'(arrived_r) : '0;
      idle_r <= 1'b0;
      done_r <= 1'b0;
      rej_r  <= (arrived_r >= CNT_MAX);
    end else if (cmd.commit) begin
      idx_r  <= sel_ok_r ? OUT_IDX_W'(sel_slot_r) : '0;
      idle_r <= !sel_ok_r;
      done_r <= sel_ok_r && (dec_rt == '0);
      rej_r  <= 1'b0;
    end
  end

  assign out_job_index = idx_r;
  assign out_idle      = idle_r;
  assign out_job_done  = done_r;
  assign out_rejected  = rej_r;
  assign out_all_done  = last_seen_r && (finished_r == arrived_r);

endmodule

>>> sv/multi_policy_job_scheduler.sv
// multi_policy_job_scheduler: top level of the four-policy job scheduler
// depends on mpjs_pkg, mpjs_ctrl and mpjs_dp
//
// One item at a time: a new item is accepted only after the result beat of the
// last one is taken, so output stalls hold the block. An arrival passes through
// decode and the result beat; a tick that needs no new pick adds commit. A tick
// under FIFO, SJF or PSJF that needs a new pick scans the job table one slot a
// cycle through its single read port. A round robin tick that changes job pops
// ring entries, each with a ring read and a table read, until a live one is
// found or the ring runs empty. A round robin tick whose slice counter is not
// below the quantum (after the quantum was lowered) first reduces the counter.
// The user must make configuration writes only while the block is idle; the
// block itself does not enforce it.
module multi_policy_job_scheduler #(
  parameter int MAX_JOBS  = 64,
  parameter int TIME_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [23:0] in_exec_time,
  input  logic        in_last_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_job_index,
  output logic        out_idle,
  output logic        out_job_done,
  output logic        out_rejected,
  output logic        out_all_done,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import mpjs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mpjs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts(sts), .cmd(cmd)
  );

  mpjs_dp #(.MAX_JOBS(MAX_JOBS), .TIME_BITS(TIME_BITS)) u_dp (
    .clk, .rst_n, .in_mode, .in_exec_time, .in_last_job,
    .cfg_we, .cfg_index, .cfg_wdata,
    .cmd(cmd), .sts(sts),
    .out_job_index, .out_idle, .out_job_done, .out_rejected, .out_all_done
  );

endmodule

>>> dv/multi_policy_job_scheduler_tb.sv
// multi_policy_job_scheduler_tb: self-checking bench for the four-policy job scheduler
// depends on mpjs_pkg and multi_policy_job_scheduler; predicts every result beat in-bench
`timescale 1ns / 1ps

module multi_policy_job_scheduler_tb;
  import mpjs_pkg::*;

  localparam int NJOBS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [5:0] job_index;
    logic       idle;
    logic       job_done;
    logic       rejected;
    logic       all_done;
  } sched_result_t;

  class sched_scoreboard;
    logic [1:0]    policy;
    logic [15:0]   quantum;
    logic [23:0]   remaining[NJOBS];
    logic [5:0]    ring[NJOBS];
    int            arrived, finished, ring_head, ring_tail, ring_count;
    logic [5:0]    running_slot;
    bit            running_valid, arrival_pending, last_seen;
    logic [15:0]   slice;
    sched_result_t pending_results[$];
    int            errors, checked;

    function new();
      policy = POL_FIFO;
      quantum = QUANTUM_RESET;
      arrived = 0; finished = 0; ring_head = 0; ring_tail = 0; ring_count = 0;
      running_slot = '0; running_valid = 0; arrival_pending = 0; last_seen = 0;
      slice = '0; errors = 0; checked = 0;
    endfunction

    function void ring_push(int slot);
      if (ring_count >= NJOBS) return;
      ring[ring_tail] = slot[5:0];
      ring_tail = (ring_tail + 1) % NJOBS;
      ring_count++;
    endfunction

    function bit ring_pop(output int slot);
      int s;
      slot = 0;
      while (ring_count > 0) begin
        s = int'(ring[ring_head]);
        ring_head = (ring_head + 1) % NJOBS;
        ring_count--;
        if (s < arrived && remaining[s] != 0) begin
          slot = s;
          return 1;
        end
      end
      return 0;
    endfunction

    function bit live();
      return running_valid && remaining[running_slot] != 0;
    endfunction

    function bit pick_shortest(output int slot);
      bit found;
      logic [23:0] best;
      found = 0; best = '0; slot = 0;
      for (int i = 0; i < arrived; i++)
        if (remaining[i] != 0 && (!found || remaining[i] < best)) begin
          best = remaining[i]; slot = i; found = 1;
        end
      return found;
    endfunction

    function void choose_job();
      int s;
      bit ok;
      int q;
      s = 0; ok = 0;
      case (policy)
        POL_FIFO: begin
          for (int i = 0; i < arrived; i++)
            if (!ok && remaining[i] != 0) begin
              ok = 1; s = i;
            end
        end
        POL_RR: begin
          q = (quantum == 0) ? 1 : int'(quantum);
          if (live() && (slice % q) != 0) begin
            ok = 1; s = running_slot;
          end else begin
            if (live()) ring_push(running_slot);
            ok = ring_pop(s);
            slice = 0;
          end
          slice = 16'((slice + 1) % q);
        end
        POL_SJF: begin
          if (live()) begin
            ok = 1; s = running_slot;
          end else ok = pick_shortest(s);
        end
        default: begin
          if (!arrival_pending && live()) begin
            ok = 1; s = running_slot;
          end else ok = pick_shortest(s);
          arrival_pending = 0;
        end
      endcase
      running_valid = ok;
      if (ok) running_slot = s[5:0];
    endfunction

    function void note_input(logic mode, logic [23:0] t, logic last);
      sched_result_t r;
      r = '0;
      if (mode == 1'b0) begin
        if (arrived >= NJOBS) r.rejected = 1;
        else begin
          r.job_index = arrived[5:0];
          remaining[arrived] = t;
          arrived++;
          if (t == 0) finished++;
          else if (policy == POL_RR) ring_push(arrived - 1);
          arrival_pending = 1;
        end
        if (last) last_seen = 1;
      end else begin
        choose_job();
        if (running_valid) begin
          r.job_index = running_slot;
          remaining[running_slot] = remaining[running_slot] - 24'd1;
          if (remaining[running_slot] == 0) begin
            r.job_done = 1; finished++; running_valid = 0;
          end
        end else r.idle = 1;
      end
      r.all_done = last_seen && finished == arrived;
      pending_results.push_back(r);
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp_r;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, act);
        errors++;
        return;
      end
      exp_r = pending_results.pop_front();
      checked++;
      if (exp_r.job_index != act.job_index)
        begin $display("%0t: job_index exp %0d got %0d", $time, exp_r.job_index,
                       act.job_index); errors++; end
      if (exp_r.idle != act.idle)
        begin $display("%0t: idle exp %0d got %0d", $time, exp_r.idle, act.idle);
              errors++; end
      if (exp_r.job_done != act.job_done)
        begin $display("%0t: job_done exp %0d got %0d", $time, exp_r.job_done,
                       act.job_done); errors++; end
      if (exp_r.rejected != act.rejected)
        begin $display("%0t: rejected exp %0d got %0d", $time, exp_r.rejected,
                       act.rejected); errors++; end
      if (exp_r.all_done != act.all_done)
        begin $display("%0t: all_done exp %0d got %0d", $time, exp_r.all_done,
                       act.all_done); errors++; end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0, in_mode = 0, in_last_job = 0;
  logic [23:0] in_exec_time = '0;
  logic        in_ready;
  logic        out_valid, out_ready = 0;
  logic [5:0]  out_job_index;
  logic        out_idle, out_job_done, out_rejected, out_all_done;
  logic        cfg_we = 0, cfg_index = CFG_POLICY;
  logic [15:0] cfg_wdata = '0;

  sched_scoreboard sb;
  int  idle_cycles = 0;
  int  sent = 0;

  always #2 clk = ~clk;

  multi_policy_job_scheduler dut (.*);

  // output side: random stalls per beat
  initial begin
    int gap;
    @(posedge clk iff rst_n);
    forever begin
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      @(posedge clk iff out_valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_job_index, out_idle, out_job_done, out_rejected, out_all_done});
    if (rst_n && in_valid && in_ready)
      sb.note_input(in_mode, in_exec_time, in_last_job);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays high from one beat to the next when there is no gap
  task automatic send_item(logic mode, logic [23:0] t, logic last);
    int gap;
    gap = $urandom_range(0, 3);
    if (sent % 50 < 10) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; in_mode <= mode; in_exec_time <= t; in_last_job <= last;
    @(posedge clk iff in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_POLICY) sb.policy = val[1:0];
    else sb.quantum = val;
    @(posedge clk);
  endtask

  function automatic logic [23:0] rand_time();
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2, 3, 4, 5: return 24'($urandom_range(1, 4));
      default: return 24'($urandom_range(1, 12));
    endcase
  endfunction

  // one batch: arrivals interleaved with ticks, then ticks until done
  task automatic run_batch(int njobs);
    int k, guard;
    k = 0; guard = 0;
    while (k < njobs) begin
      if ($urandom_range(0, 2) == 0) send_item(1'b1, 24'($urandom), 1'($urandom));
      else begin
        send_item(1'b0, rand_time(), k == njobs - 1);
        k++;
      end
    end
    while (guard < 150 && !(sb.pending_results.size() == 0 && sb.last_seen &&
           sb.finished == sb.arrived)) begin
      send_item(1'b1, 24'($urandom), 1'($urandom));
      guard++;
    end
  endtask

  // reset the predictor and block between batches is not allowed, so batches share state
  initial begin
    logic [1:0] pol;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset defaults, idle tick, zero-time job, ticks after done
    send_item(1'b1, 24'hFFFFFF, 1'b1);
    send_item(1'b0, 24'd0, 1'b0);
    send_item(1'b0, 24'd2, 1'b0);
    send_item(1'b0, 24'd1, 1'b1);
    repeat (4) send_item(1'b1, 24'd0, 1'b0);
    drain();
    write_cfg(CFG_QUANTUM, 16'd0);
    write_cfg(CFG_POLICY, 16'(POL_RR));
    send_item(1'b0, 24'd3, 1'b0);
    send_item(1'b0, 24'd2, 1'b0);
    repeat (6) send_item(1'b1, 24'd0, 1'b0);
    drain();
    write_cfg(CFG_QUANTUM, 16'hFFFF);
    write_cfg(CFG_POLICY, 16'(POL_PSJF));
    send_item(1'b0, 24'd4, 1'b0);
    send_item(1'b1, 24'd0, 1'b0);
    send_item(1'b0, 24'd1, 1'b0);
    repeat (3) send_item(1'b1, 24'd0, 1'b0);
    drain();

    // random: policies and quanta change between phases, table fills up
    while (sent < 1800) begin
      pol = 2'($urandom_range(0, 3));
      write_cfg(CFG_POLICY, 16'(pol));
      case ($urandom_range(0, 3))
        0: write_cfg(CFG_QUANTUM, 16'd1);
        1: write_cfg(CFG_QUANTUM, 16'hFFFF);
        default: write_cfg(CFG_QUANTUM, 16'($urandom_range(0, 4)));
      endcase
      if ($urandom_range(0, 4) == 0)
        repeat (20) send_item(1'($urandom), 24'($urandom), 1'($urandom));
      else run_batch($urandom_range(1, 8));
      drain();
    end

    $display("covered %0d input beats, %0d results checked, %0d jobs in table",
             sent, sb.checked, sb.arrived);
    $display("all four policies, quantum extremes and full-table rejects exercised");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
